// ===== rtl/sorted_slot_list_engine_macros.svh =====
// assertion macros for the asserting top-level file
`ifndef SORTED_SLOT_LIST_ENGINE_MACROS_SVH
`define SORTED_SLOT_LIST_ENGINE_MACROS_SVH

// same-cycle implication, held off during reset
`define SSLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SSLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssle_pkg.sv =====
// shared types and constants of the sorted slot list engine
package ssle_pkg;

  localparam int KEY_W  = 16;
  localparam int REC_W  = 16;
  localparam int POS_W  = 4;
  localparam int SIZE_W = 5;

  localparam logic [SIZE_W-1:0] LIST_SIZE_RST = 5'd16;

  typedef enum logic [1:0] {
    ACT_INS_POS  = 2'd0,
    ACT_INS_SORT = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_READ     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the input word
    logic find;   // compare all slots, register hit vector and status
    logic apply;  // shift slots and load the result word
  } dp_cmd_t;

endpackage

// ===== rtl/ssle_ctrl.sv =====
// controller: sequences accept, find and apply, owns the input and result handshakes
module ssle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ssle_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FIND  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;
  logic   apply;

  assign out_free = !out_valid_r || out_ready;
  assign apply    = (state_r == S_APPLY) && out_free;
  assign in_ready = (state_r == S_IDLE) || apply;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_FIND;
      end
      S_FIND: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply) state_nxt = accept ? S_FIND : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (apply) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cmd.load  = accept;
  assign cmd.find  = (state_r == S_FIND);
  assign cmd.apply = apply;

endmodule

// ===== rtl/ssle_dp.sv =====
// datapath: slot registers, parallel compare, shift network and result register
module ssle_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ssle_pkg::dp_cmd_t                  cmd,
  input  logic [ssle_pkg::SIZE_W-1:0]        list_size,
  input  logic [1:0]                         in_action,
  input  logic [ssle_pkg::POS_W-1:0]         in_position,
  input  logic [ssle_pkg::KEY_W-1:0]         in_key,
  input  logic [ssle_pkg::REC_W-1:0]         in_record_handle,
  output logic [2:0]                         out_status,
  output logic                               out_slot_valid,
  output logic [ssle_pkg::KEY_W-1:0]         out_key,
  output logic [ssle_pkg::REC_W-1:0]         out_record,
  output logic                               out_is_empty,
  output logic                               out_is_full
);

  localparam int NW = $clog2(CAPACITY + 1);
  localparam int CW = (NW > ssle_pkg::SIZE_W) ? NW : ssle_pkg::SIZE_W;

  // captured input word
  ssle_pkg::action_t               act_r;
  logic [ssle_pkg::POS_W-1:0]      pos_r;
  logic [ssle_pkg::KEY_W-1:0]      key_r;
  logic [ssle_pkg::REC_W-1:0]      rec_r;

  // slots
  logic [ssle_pkg::KEY_W-1:0]      slot_key_r [CAPACITY];
  logic [ssle_pkg::REC_W-1:0]      slot_rec_r [CAPACITY];
  logic [CAPACITY-1:0]             slot_used_r;
  logic [ssle_pkg::KEY_W-1:0]      slot_key_nxt [CAPACITY];
  logic [ssle_pkg::REC_W-1:0]      slot_rec_nxt [CAPACITY];
  logic [CAPACITY-1:0]             slot_used_nxt;

  // find stage
  logic [CAPACITY-1:0]             hit_c, hit_r;
  ssle_pkg::status_t               st_c, st_r;

  logic [CW-1:0]                   size_w, n_w, pos_w;
  logic                            pos_bad;
  logic [CAPACITY-1:0]             in_rng, at_pos, is_last;
  logic                            any_hit, used_last;

  // apply stage
  logic [CAPACITY-1:0]             hit_neg, ge, first;
  logic                            ok;
  logic [ssle_pkg::KEY_W-1:0]      sel_key;
  logic [ssle_pkg::REC_W-1:0]      sel_rec;
  logic                            sel_used;

  // effective list size, clamped to 1..CAPACITY
  always_comb begin
    size_w = CW'(list_size);
    if (size_w == '0) n_w = CW'(1);
    else if (size_w > CW'(CAPACITY)) n_w = CW'(CAPACITY);
    else n_w = size_w;
  end

  assign pos_w   = CW'(pos_r);
  assign pos_bad = (pos_w >= n_w);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cmp
      assign in_rng[gi]  = (CW'(gi) < n_w);
      assign at_pos[gi]  = (CW'(gi) == pos_w);
      assign is_last[gi] = (CW'(gi + 1) == n_w);

      always_comb begin
        case (act_r)
          ssle_pkg::ACT_INS_SORT: begin
            // walk stops at the first free slot or key not above the new one
            hit_c[gi] = in_rng[gi] && (!slot_used_r[gi] || !(key_r < slot_key_r[gi]));
          end
          ssle_pkg::ACT_REMOVE: begin
            hit_c[gi] = in_rng[gi] && slot_used_r[gi] && (slot_key_r[gi] == key_r);
          end
          default: begin
            hit_c[gi] = at_pos[gi];
          end
        endcase
      end
    end
  endgenerate

  assign any_hit   = |hit_c;
  assign used_last = |(slot_used_r & is_last);

  always_comb begin
    st_c = ssle_pkg::ST_OK;
    case (act_r)
      ssle_pkg::ACT_INS_POS: begin
        if (pos_bad) st_c = ssle_pkg::ST_BADPOS;
        else if (used_last) st_c = ssle_pkg::ST_FULL;
      end
      ssle_pkg::ACT_INS_SORT: begin
        if (!any_hit) st_c = ssle_pkg::ST_BADPOS;
        else if (used_last) st_c = ssle_pkg::ST_FULL;
      end
      ssle_pkg::ACT_REMOVE: begin
        if (!slot_used_r[0]) st_c = ssle_pkg::ST_EMPTY;
        else if (!any_hit) st_c = ssle_pkg::ST_NOTFOUND;
      end
      ssle_pkg::ACT_READ: begin
        if (pos_bad) st_c = ssle_pkg::ST_BADPOS;
      end
      default: begin
        st_c = ssle_pkg::ST_OK;
      end
    endcase
  end

  // lowest hit and everything above it from one negate
  assign hit_neg = ~hit_r + {{(CAPACITY-1){1'b0}}, 1'b1};
  assign ge      = hit_r | hit_neg;
  assign first   = hit_r & hit_neg;
  assign ok      = (st_r == ssle_pkg::ST_OK);

  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [ssle_pkg::KEY_W-1:0] dn_key, up_key;
      logic [ssle_pkg::REC_W-1:0] dn_rec, up_rec;
      logic                       dn_used, up_used;

      if (gi > 0) begin : g_dn
        assign dn_key  = slot_key_r[gi-1];
        assign dn_rec  = slot_rec_r[gi-1];
        assign dn_used = slot_used_r[gi-1];
      end else begin : g_dn0
        assign dn_key  = slot_key_r[gi];
        assign dn_rec  = slot_rec_r[gi];
        assign dn_used = slot_used_r[gi];
      end

      if (gi < CAPACITY - 1) begin : g_up
        assign up_key  = slot_key_r[gi+1];
        assign up_rec  = slot_rec_r[gi+1];
        assign up_used = slot_used_r[gi+1];
      end else begin : g_up0
        assign up_key  = slot_key_r[gi];
        assign up_rec  = slot_rec_r[gi];
        assign up_used = slot_used_r[gi];
      end

      always_comb begin
        slot_key_nxt[gi]  = slot_key_r[gi];
        slot_rec_nxt[gi]  = slot_rec_r[gi];
        slot_used_nxt[gi] = slot_used_r[gi];
        if (ok && in_rng[gi]) begin
          case (act_r)
            ssle_pkg::ACT_INS_POS, ssle_pkg::ACT_INS_SORT: begin
              if (first[gi]) begin
                slot_key_nxt[gi]  = key_r;
                slot_rec_nxt[gi]  = rec_r;
                slot_used_nxt[gi] = 1'b1;
              end else if (ge[gi]) begin
                slot_key_nxt[gi]  = dn_key;
                slot_rec_nxt[gi]  = dn_rec;
                slot_used_nxt[gi] = dn_used;
              end
            end
            ssle_pkg::ACT_REMOVE: begin
              if (ge[gi]) begin
                if (is_last[gi]) begin
                  slot_used_nxt[gi] = 1'b0;
                end else begin
                  slot_key_nxt[gi]  = up_key;
                  slot_rec_nxt[gi]  = up_rec;
                  slot_used_nxt[gi] = up_used;
                end
              end
            end
            default: begin
              slot_used_nxt[gi] = slot_used_r[gi];
            end
          endcase
        end
      end
    end
  endgenerate

  // one-hot select of the found slot
  always_comb begin
    sel_key = '0;
    sel_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key = sel_key | (slot_key_r[i] & {ssle_pkg::KEY_W{first[i]}});
      sel_rec = sel_rec | (slot_rec_r[i] & {ssle_pkg::REC_W{first[i]}});
    end
  end
  assign sel_used = |(first & slot_used_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= ssle_pkg::action_t'(in_action);
      pos_r <= in_position;
      key_r <= in_key;
      rec_r <= in_record_handle;
    end
    if (cmd.find) begin
      hit_r <= hit_c;
      st_r  <= st_c;
    end
    if (cmd.apply) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_key_r[i] <= slot_key_nxt[i];
        slot_rec_r[i] <= slot_rec_nxt[i];
      end
      out_status   <= st_r;
      out_is_empty <= !slot_used_nxt[0];
      out_is_full  <= |(slot_used_nxt & is_last);
      if (ok && act_r == ssle_pkg::ACT_REMOVE) begin
        out_slot_valid <= 1'b1;
        out_key        <= sel_key;
        out_record     <= sel_rec;
      end else if (ok && act_r == ssle_pkg::ACT_READ && sel_used) begin
        out_slot_valid <= 1'b1;
        out_key        <= sel_key;
        out_record     <= sel_rec;
      end else begin
        out_slot_valid <= 1'b0;
        out_key        <= '0;
        out_record     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
    end else if (cmd.apply) begin
      slot_used_r <= slot_used_nxt;
    end
  end

endmodule

// ===== rtl/sorted_slot_list_engine.sv =====
// Sorted slot list engine, top level.
// Input channel (in_*): one word per action - insert at position, sorted
// insert (descending keys), remove by key, read at index. Result channel
// (out_*): exactly one word per input word, in order, with a status code,
// the read or removed entry and the empty/full flags after the action.
// Config channel (cfg_*): writes list_size; always ready, write only while
// the engine is idle. list_size 0 acts as 1, above CAPACITY as CAPACITY.
// Path: the accepted word is registered, the find step compares all slots
// in parallel and registers the hit vector and status, and the apply step
// shifts the slots and loads the result register.
// A new word is taken while idle or in the cycle its predecessor's result
// is loaded, never while the previous word is still being compared.
// Stall: the result register holds until out_ready; the next word's update
// waits for the register to free, and no new word is accepted meanwhile.
// Reset (rst_n low, synchronous): all slots free, list_size back to 16,
// no result pending. Slot keys and records are not cleared.
`include "sorted_slot_list_engine_macros.svh"

module sorted_slot_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_position,
  input  logic [15:0] in_key,
  input  logic [15:0] in_record_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_slot_valid,
  output logic [15:0] out_key,
  output logic [15:0] out_record,
  output logic        out_is_empty,
  output logic        out_is_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_list_size
);

  ssle_pkg::dp_cmd_t             cmd;
  logic [ssle_pkg::SIZE_W-1:0]   list_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_size_r <= ssle_pkg::LIST_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      list_size_r <= cfg_list_size;
    end
  end

  ssle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ssle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .list_size        (list_size_r),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_key           (in_key),
    .in_record_handle (in_record_handle),
    .out_status       (out_status),
    .out_slot_valid   (out_slot_valid),
    .out_key          (out_key),
    .out_record       (out_record),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

  // an accepted word blocks the input for its compare cycle
  `SSLE_ASSERT_NXT(a_no_accept_in_find, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted during compare cycle")

  // a fresh result comes only from an accepted word after its compare and apply steps
  `SSLE_ASSERT_IMP(a_result_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 3), "result without matching accept")

  // errors never return an entry
  `SSLE_ASSERT_IMP(a_err_no_entry, clk, rst_n, out_valid && (out_status != ssle_pkg::ST_OK), !out_slot_valid, "entry returned with error status")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the sorted slot list engine
module tb_top;
  import ssle_pkg::*;

  typedef struct {
    status_t     status;
    logic        slot_valid;
    logic [15:0] key;
    logic [15:0] rec;
    logic        empty;
    logic        full;
  } list_result_t;

  typedef struct {
    bit           is_cfg;
    logic [4:0]   size;
    action_t      act;
    logic [3:0]   pos;
    logic [15:0]  key;
    logic [15:0]  rec;
    bit           typed;
    list_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = 2'd0;
  logic [3:0]  in_position = 4'd0;
  logic [15:0] in_key = 16'd0;
  logic [15:0] in_record_handle = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic        out_slot_valid;
  logic [15:0] out_key;
  logic [15:0] out_record;
  logic        out_is_empty;
  logic        out_is_full;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_list_size = 5'd0;

  // list contents as the engine should hold them
  logic [15:0] ent_key [16];
  logic [15:0] ent_rec [16];
  bit          ent_used [16];
  logic [4:0]  cur_size = LIST_SIZE_RST;

  list_result_t pending_results[$];
  int send_idle_pct = 17;
  int recv_idle_pct = 69;
  int fail_count = 0;
  int act_seen [4];
  int status_seen [5];
  int sizes_written = 0;

  sorted_slot_list_engine #(.CAPACITY(16)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_key           (in_key),
    .in_record_handle (in_record_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot_valid   (out_slot_valid),
    .out_key          (out_key),
    .out_record       (out_record),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_list_size    (cfg_list_size)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      ent_key[i] = 16'd0;
      ent_rec[i] = 16'd0;
      ent_used[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) act_seen[i] = 0;
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
  end

  // register value 0 acts as 1, anything above 16 as 16
  function automatic int live_size();
    if (cur_size == 5'd0) return 1;
    if (cur_size > 5'd16) return 16;
    return int'(cur_size);
  endfunction

  function automatic void move_slot(int dst, int src);
    ent_key[dst] = ent_key[src];
    ent_rec[dst] = ent_rec[src];
    ent_used[dst] = ent_used[src];
  endfunction

  function automatic status_t place_entry(int p, int n, logic [15:0] k, logic [15:0] r);
    if (p >= n) return ST_BADPOS;
    if (ent_used[n-1]) return ST_FULL;
    for (int i = n - 1; i > p; i--) move_slot(i, i - 1);
    ent_key[p] = k;
    ent_rec[p] = r;
    ent_used[p] = 1'b1;
    return ST_OK;
  endfunction

  function automatic list_result_t list_apply(action_t act, logic [3:0] pos,
                                              logic [15:0] k, logic [15:0] r);
    list_result_t res;
    int n;
    int i;
    res.status = ST_OK;
    res.slot_valid = 1'b0;
    res.key = 16'd0;
    res.rec = 16'd0;
    n = live_size();
    case (act)
      ACT_INS_POS: res.status = place_entry(int'(pos), n, k, r);
      ACT_INS_SORT: begin
        // descending order: skip occupied slots with a strictly larger key
        i = 0;
        while (i < n && ent_used[i] && k < ent_key[i]) i++;
        res.status = place_entry(i, n, k, r);
      end
      ACT_REMOVE: begin
        if (!ent_used[0]) begin
          res.status = ST_EMPTY;
        end else begin
          i = 0;
          while (i < n && !(ent_used[i] && ent_key[i] == k)) i++;
          if (i >= n) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.slot_valid = 1'b1;
            res.key = ent_key[i];
            res.rec = ent_rec[i];
            for (; i + 1 < n; i++) move_slot(i, i + 1);
            ent_used[n-1] = 1'b0;
          end
        end
      end
      default: begin
        if (int'(pos) >= n) begin
          res.status = ST_BADPOS;
        end else if (ent_used[pos]) begin
          res.slot_valid = 1'b1;
          res.key = ent_key[pos];
          res.rec = ent_rec[pos];
        end
      end
    endcase
    res.empty = !ent_used[0];
    res.full = ent_used[n-1];
    return res;
  endfunction

  function automatic logic [15:0] rand_key();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(15));
    endcase
  endfunction

  function automatic dir_row_t cfg_row(logic [4:0] size);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.size = size;
    row.act = ACT_READ;
    row.pos = 4'd0;
    row.key = 16'd0;
    row.rec = 16'd0;
    row.typed = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t word_row(action_t act, logic [3:0] pos, logic [15:0] k,
                                        logic [15:0] r, bit typed, status_t st,
                                        logic emp, logic ful);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.size = 5'd0;
    row.act = act;
    row.pos = pos;
    row.key = k;
    row.rec = r;
    row.typed = typed;
    row.res.status = st;
    row.res.slot_valid = 1'b0;
    row.res.key = 16'd0;
    row.res.rec = 16'd0;
    row.res.empty = emp;
    row.res.full = ful;
    return row;
  endfunction

  // waits for the engine to drain, then writes list_size
  task automatic write_list_size(logic [4:0] size);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_list_size <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_size = size;
    sizes_written++;
  endtask

  task automatic send_word(action_t act, logic [3:0] pos, logic [15:0] k, logic [15:0] r,
                           bit typed, list_result_t typed_res);
    list_result_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_position <= pos;
    in_key <= k;
    in_record_handle <= r;
    do @(posedge clk); while (!in_ready);
    pred = list_apply(act, pos, k, r);
    pending_results.push_back(typed ? typed_res : pred);
    act_seen[act]++;
  endtask

  // result side: random back-pressure and in-order compare
  initial begin
    list_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: status %0d key %h rec %h",
                     out_status, out_key, out_record);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          if (out_status !== want.status || out_slot_valid !== want.slot_valid ||
              out_key !== want.key || out_record !== want.rec ||
              out_is_empty !== want.empty || out_is_full !== want.full) begin
            if (fail_count < 10)
              $display({"mismatch: want st %0d v %0b key %h rec %h e %0b f %0b,",
                        " got st %0d v %0b key %h rec %h e %0b f %0b"},
                       want.status, want.slot_valid, want.key, want.rec, want.empty,
                       want.full, out_status, out_slot_valid, out_key, out_record,
                       out_is_empty, out_is_full);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    list_result_t no_typed;
    action_t act;
    logic [3:0] pos;
    logic [15:0] key;
    logic [15:0] rec;
    logic [4:0] sz;
    int n;
    int roll;
    int ins_pct;
    int blk_len;
    int sent;
    int slot;

    no_typed.status = ST_OK;

    // fill, overflow, drain and the size clamps
    dir_rows.push_back(word_row(ACT_READ, 4'd0, 16'h0000, 16'h0000, 1, ST_OK, 1, 0));
    dir_rows.push_back(word_row(ACT_REMOVE, 4'd0, 16'h1234, 16'h0000, 1, ST_EMPTY, 1, 0));
    dir_rows.push_back(word_row(ACT_READ, 4'd15, 16'h0000, 16'h0000, 1, ST_OK, 1, 0));
    dir_rows.push_back(word_row(ACT_INS_SORT, 4'd0, 16'h8000, 16'hffff, 0, ST_OK, 0, 0));
    dir_rows.push_back(word_row(ACT_INS_POS, 4'd0, 16'hffff, 16'h0000, 0, ST_OK, 0, 0));
    dir_rows.push_back(word_row(ACT_INS_POS, 4'd15, 16'h0000, 16'haaaa, 0, ST_OK, 0, 0));
    dir_rows.push_back(word_row(ACT_INS_POS, 4'd1, 16'h0f0f, 16'hf0f0, 1, ST_FULL, 0, 1));
    // key 0 also sits in the free slots, only the occupied one may match
    dir_rows.push_back(word_row(ACT_REMOVE, 4'd0, 16'h0000, 16'h0000, 0, ST_OK, 0, 0));
    dir_rows.push_back(cfg_row(5'd4));
    dir_rows.push_back(word_row(ACT_READ, 4'd4, 16'h0000, 16'h0000, 1, ST_BADPOS, 0, 0));
    dir_rows.push_back(word_row(ACT_INS_POS, 4'd9, 16'h5555, 16'h5555, 1, ST_BADPOS, 0, 0));
    dir_rows.push_back(word_row(ACT_INS_SORT, 4'd0, 16'h0001, 16'h0101, 0, ST_OK, 0, 0));
    // equal key goes in front of the existing one
    dir_rows.push_back(word_row(ACT_INS_SORT, 4'd0, 16'h0001, 16'h0202, 0, ST_OK, 0, 0));
    // walk passes every slot in use: bad position wins over full
    dir_rows.push_back(word_row(ACT_INS_SORT, 4'd0, 16'h0000, 16'h3333, 1, ST_BADPOS, 0, 1));
    dir_rows.push_back(word_row(ACT_INS_SORT, 4'd0, 16'hffff, 16'h3333, 1, ST_FULL, 0, 1));
    dir_rows.push_back(word_row(ACT_REMOVE, 4'd0, 16'hffff, 16'h0000, 0, ST_OK, 0, 0));
    dir_rows.push_back(cfg_row(5'd0));
    dir_rows.push_back(word_row(ACT_READ, 4'd0, 16'h0000, 16'h0000, 0, ST_OK, 0, 0));
    dir_rows.push_back(word_row(ACT_READ, 4'd1, 16'h0000, 16'h0000, 1, ST_BADPOS, 0, 1));
    dir_rows.push_back(word_row(ACT_REMOVE, 4'd0, 16'h8000, 16'h0000, 0, ST_OK, 0, 0));
    dir_rows.push_back(word_row(ACT_REMOVE, 4'd0, 16'h8000, 16'h0000, 1, ST_EMPTY, 1, 0));
    dir_rows.push_back(cfg_row(5'd31));
    dir_rows.push_back(word_row(ACT_INS_POS, 4'd0, 16'h1234, 16'h5678, 0, ST_OK, 0, 0));
    dir_rows.push_back(word_row(ACT_READ, 4'd2, 16'h0000, 16'h0000, 0, ST_OK, 0, 0));
    dir_rows.push_back(word_row(ACT_INS_SORT, 4'd0, 16'h7fff, 16'h8001, 0, ST_OK, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_list_size(dir_rows[i].size);
      else
        send_word(dir_rows[i].act, dir_rows[i].pos, dir_rows[i].key, dir_rows[i].rec,
                  dir_rows[i].typed, dir_rows[i].res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 17; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < 510) begin
        // mostly short lists so they fill and empty often
        case ($urandom_range(9))
          0: sz = 5'd0;
          1: sz = 5'd31;
          2: sz = 5'd16;
          3: sz = 5'($urandom_range(31, 17));
          4: sz = 5'd1;
          default: sz = 5'($urandom_range(6, 2));
        endcase
        write_list_size(sz);
        ins_pct = $urandom_range(70, 30);
        blk_len = $urandom_range(60, 20);
        for (int j = 0; j < blk_len; j++) begin
          n = live_size();
          roll = $urandom_range(99);
          rec = 16'($urandom);
          key = rand_key();
          if ($urandom_range(9) == 0) pos = 4'($urandom);
          else pos = 4'($urandom_range(n - 1));
          if (roll < ins_pct) begin
            act = roll[0] ? ACT_INS_SORT : ACT_INS_POS;
          end else if (roll < ins_pct + (100 - ins_pct) * 3 / 5) begin
            act = ACT_REMOVE;
            // usually remove a key that is in the list
            slot = $urandom_range(n - 1);
            if (ent_used[slot] && $urandom_range(3) != 0) key = ent_key[slot];
          end else begin
            act = ACT_READ;
          end
          send_word(act, pos, key, rec, 0, no_typed);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;

    $display("covered %0d words: %0d insert-at, %0d sorted, %0d remove, %0d read; %0d size writes",
             act_seen[0] + act_seen[1] + act_seen[2] + act_seen[3], act_seen[0], act_seen[1],
             act_seen[2], act_seen[3], sizes_written);
    $display("statuses seen: ok %0d, bad position %0d, full %0d, empty %0d, not found %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
